@@ src/agpf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// agpf_pkg
// Types and constants shared by the ARMA-GARCH panel filter modules.
// ----------------------------------------------------------------------------
package agpf_pkg;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic [1:0] BANK_LAMBDA = 2'd0;
    localparam logic [1:0] BANK_RHO    = 2'd1;
    localparam logic [1:0] BANK_GAMMA  = 2'd2;
    localparam logic [1:0] BANK_PSI    = 2'd3;

    localparam logic [1:0] CFG_AR    = 2'd0;
    localparam logic [1:0] CFG_MA    = 2'd1;
    localparam logic [1:0] CFG_GARCH = 2'd2;
    localparam logic [1:0] CFG_ARCH  = 2'd3;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         individual;
        logic               first_period;
        logic signed [31:0] sample_value;
        logic [1:0]         coef_bank;
        logic [2:0]         coef_index;
        logic signed [31:0] coef_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         individual_out;
        logic signed [31:0] residual;
        logic signed [31:0] log_variance;
        logic               saturated;
    } t_out_word;

    // Queue word: a load or a sample that the front has already checked.
    typedef struct packed {
        logic               is_load;
        logic [7:0]         individual;
        logic               first_period;
        logic signed [31:0] value;
        logic [1:0]         coef_bank;
        logic [2:0]         coef_index;
    } t_q_word;

endpackage
`default_nettype wire

@@ src/agpf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// agpf_front
// Accepts input words, drops those that have no effect, and queues the rest.
// ----------------------------------------------------------------------------
module agpf_front #(
    parameter int MAX_IND   = 256,
    parameter int MAX_ORDER = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire agpf_pkg::t_in_word i_data,
    output logic                    o_q_valid,
    input  wire logic               i_q_ready,
    output agpf_pkg::t_q_word       o_q_data
);
    import agpf_pkg::*;

    t_q_word    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    logic       push;
    logic       pop;
    t_q_word    q_in;

    // Out-of-range loads and samples for unknown individuals leave no trace.
    always_comb begin
        if (i_data.opcode == OP_LOAD) begin
            keep = int'(i_data.coef_index) < MAX_ORDER;
        end else begin
            keep = int'(i_data.individual) < MAX_IND;
        end
        q_in.is_load      = (i_data.opcode == OP_LOAD);
        q_in.individual   = i_data.individual;
        q_in.first_period = i_data.first_period;
        q_in.value        = (i_data.opcode == OP_LOAD) ? i_data.coef_value
                                                       : i_data.sample_value;
        q_in.coef_bank    = i_data.coef_bank;
        q_in.coef_index   = i_data.coef_index;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= q_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

@@ src/agpf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// agpf_back
// Sequencer with one shared multiplier: loads coefficients, runs the ARMA and
// GARCH tap sums over per-individual ring-buffer histories, writes results.
// ----------------------------------------------------------------------------
module agpf_back #(
    parameter int MAX_IND   = 256,
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [3:0]        i_cfg_data,
    input  wire logic              i_q_valid,
    output logic                   o_q_ready,
    input  wire agpf_pkg::t_q_word i_q_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output agpf_pkg::t_out_word    o_data
);
    import agpf_pkg::*;

    localparam int KW    = $clog2(MAX_ORDER + 1);
    localparam int LW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int IW    = (MAX_IND > 1) ? $clog2(MAX_IND) : 1;
    localparam int DEPTH = MAX_IND * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NC    = 4 * MAX_ORDER;
    localparam int CW    = $clog2(NC);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_META   = 4'd1;
    localparam logic [3:0] S_ANEXT  = 4'd2;
    localparam logic [3:0] S_AFETCH = 4'd3;
    localparam logic [3:0] S_ADISP  = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_ACC    = 4'd6;
    localparam logic [3:0] S_ECLIP  = 4'd7;
    localparam logic [3:0] S_GNEXT  = 4'd8;
    localparam logic [3:0] S_GFETCH = 4'd9;
    localparam logic [3:0] S_GDISP  = 4'd10;
    localparam logic [3:0] S_LCLIP  = 4'd11;
    localparam logic [3:0] S_WB     = 4'd12;

    localparam logic [2:0] OP_RHO0 = 3'd0;
    localparam logic [2:0] OP_RHO  = 3'd1;
    localparam logic [2:0] OP_LAM  = 3'd2;
    localparam logic [2:0] OP_SQE  = 3'd3;
    localparam logic [2:0] OP_PSI0 = 3'd4;
    localparam logic [2:0] OP_SQH  = 3'd5;
    localparam logic [2:0] OP_PSI  = 3'd6;
    localparam logic [2:0] OP_GAM  = 3'd7;

    logic signed [31:0] r_coef [NC];
    logic signed [31:0] hist_u [DEPTH];
    logic signed [31:0] hist_e [DEPTH];
    logic signed [31:0] hist_v [DEPTH];
    logic [KW+LW-1:0]   meta_mem [MAX_IND];

    logic [3:0]         r_ar, r_ma, r_garch, r_arch;
    logic [3:0]         r_state;
    logic [2:0]         r_op;
    t_q_word            r_item;
    logic [KW+LW-1:0]   r_meta_rd;
    logic [KW-1:0]      r_seen;
    logic [KW-1:0]      r_k;
    logic [LW-1:0]      r_head;
    logic [LW-1:0]      r_slot;
    logic signed [31:0] r_uh, r_eh, r_vh;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_e;
    logic signed [31:0] r_lnv;
    logic signed [31:0] r_sq;
    logic               r_sat;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [KW-1:0]      nar, nma, ngm, nps;
    logic               rho_on, lam_on, psi_on, gam_on, more;
    logic signed [31:0] mul_a, mul_b;
    logic [CW-1:0]      cidx;
    logic signed [63:0] term;
    logic               fetch;
    logic               wb_en;
    logic [LW-1:0]      new_head;
    logic [AW-1:0]      rd_addr, wb_addr;
    logic [IW-1:0]      ind_q, ind_r;
    logic [KW-1:0]      seen_raw;

    function automatic logic [KW-1:0] ord_eff(input logic [3:0] r);
        if (int'(r) > MAX_ORDER) begin
            return KW'(MAX_ORDER);
        end
        return KW'(r);
    endfunction

    function automatic logic [LW-1:0] slot_dec(input logic [LW-1:0] s);
        if (s == '0) begin
            return LW'(MAX_ORDER - 1);
        end
        return s - LW'(1);
    endfunction

    always_comb begin
        nar = ord_eff(r_ar);
        nma = ord_eff(r_ma);
        ngm = ord_eff(r_garch);
        nps = ord_eff(r_arch);
        rho_on = ({1'b0, r_k} + (KW + 1)'(1)) < {1'b0, nma};
        psi_on = ({1'b0, r_k} + (KW + 1)'(1)) < {1'b0, nps};
        lam_on = r_k < nar;
        gam_on = r_k < ngm;
        more   = r_k < r_seen;
        ind_q  = IW'(i_q_data.individual);
        ind_r  = IW'(r_item.individual);
        seen_raw = r_meta_rd[KW+LW-1:LW];
        new_head = (r_head == LW'(MAX_ORDER - 1)) ? '0 : r_head + LW'(1);
        rd_addr  = AW'(int'(r_item.individual) * MAX_ORDER + int'(r_slot));
        wb_addr  = AW'(int'(r_item.individual) * MAX_ORDER + int'(new_head));
        fetch    = (r_state == S_AFETCH) || (r_state == S_GFETCH);
        wb_en    = (r_state == S_WB) && !r_out_valid;
        term     = r_prod >>> FRAC_BITS;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        cidx  = '0;
        mul_a = r_e;
        mul_b = r_e;
        unique case (r_op)
            OP_RHO0: begin
                cidx  = CW'(MAX_ORDER);
                mul_a = r_coef[cidx];
                mul_b = r_item.value;
            end
            OP_RHO: begin
                cidx  = CW'(MAX_ORDER + int'(r_k) + 1);
                mul_a = r_coef[cidx];
                mul_b = r_uh;
            end
            OP_LAM: begin
                cidx  = CW'(int'(r_k));
                mul_a = r_coef[cidx];
                mul_b = r_eh;
            end
            OP_SQE: begin
                mul_a = r_e;
                mul_b = r_e;
            end
            OP_PSI0: begin
                cidx  = CW'(3 * MAX_ORDER);
                mul_a = r_coef[cidx];
                mul_b = r_sq;
            end
            OP_SQH: begin
                mul_a = r_eh;
                mul_b = r_eh;
            end
            OP_PSI: begin
                cidx  = CW'(3 * MAX_ORDER + int'(r_k) + 1);
                mul_a = r_coef[cidx];
                mul_b = r_sq;
            end
            OP_GAM: begin
                cidx  = CW'(2 * MAX_ORDER + int'(r_k));
                mul_a = r_coef[cidx];
                mul_b = r_vh;
            end
            default: begin
                mul_a = r_e;
            end
        endcase
    end

    assign o_q_ready = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_ff @(posedge i_clk) begin
        r_meta_rd <= meta_mem[ind_q];
        if (fetch) begin
            r_uh <= hist_u[rd_addr];
            r_eh <= hist_e[rd_addr];
            r_vh <= hist_v[rd_addr];
        end
        if (wb_en) begin
            hist_u[wb_addr]  <= r_item.value;
            hist_e[wb_addr]  <= r_e;
            hist_v[wb_addr]  <= r_lnv;
            meta_mem[ind_r]  <= {(r_seen < KW'(MAX_ORDER)) ? r_seen + KW'(1)
                                                          : KW'(MAX_ORDER), new_head};
        end
        if (r_state == S_MUL) begin
            r_prod <= $signed(mul_a) * $signed(mul_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ar        <= 4'd0;
            r_ma        <= 4'd1;
            r_garch     <= 4'd0;
            r_arch      <= 4'd1;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_seen      <= '0;
            for (int i = 0; i < NC; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_AR:    r_ar    <= i_cfg_data;
                    CFG_MA:    r_ma    <= i_cfg_data;
                    CFG_GARCH: r_garch <= i_cfg_data;
                    CFG_ARCH:  r_arch  <= i_cfg_data;
                    default:   r_ar    <= r_ar;
                endcase
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_data;
                        if (i_q_data.is_load) begin
                            r_coef[CW'(int'(i_q_data.coef_bank) * MAX_ORDER
                                   + int'(i_q_data.coef_index))] <= i_q_data.value;
                        end else begin
                            r_state <= S_META;
                        end
                    end
                end
                S_META: begin
                    // A first period starts the ring at slot zero with no history.
                    if (r_item.first_period) begin
                        r_seen <= '0;
                        r_head <= '0;
                        r_slot <= '0;
                    end else begin
                        r_seen <= (seen_raw > KW'(MAX_ORDER)) ? KW'(MAX_ORDER) : seen_raw;
                        r_head <= r_meta_rd[LW-1:0];
                        r_slot <= r_meta_rd[LW-1:0];
                    end
                    r_k   <= '0;
                    r_acc <= '0;
                    r_sat <= 1'b0;
                    if (nma != '0) begin
                        r_op    <= OP_RHO0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_ANEXT;
                    end
                end
                S_ANEXT: begin
                    r_state <= more ? S_AFETCH : S_ECLIP;
                end
                S_AFETCH: begin
                    r_state <= S_ADISP;
                end
                S_ADISP: begin
                    if (rho_on) begin
                        r_op    <= OP_RHO;
                        r_state <= S_MUL;
                    end else if (lam_on) begin
                        r_op    <= OP_LAM;
                        r_state <= S_MUL;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_slot  <= slot_dec(r_slot);
                        r_state <= S_ANEXT;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    unique case (r_op) inside
                        OP_RHO0: begin
                            r_acc   <= r_acc + term;
                            r_state <= S_ANEXT;
                        end
                        OP_RHO: begin
                            r_acc <= r_acc + term;
                            if (lam_on) begin
                                r_op    <= OP_LAM;
                                r_state <= S_MUL;
                            end else begin
                                r_k     <= r_k + KW'(1);
                                r_slot  <= slot_dec(r_slot);
                                r_state <= S_ANEXT;
                            end
                        end
                        OP_LAM: begin
                            r_acc   <= r_acc - term;
                            r_k     <= r_k + KW'(1);
                            r_slot  <= slot_dec(r_slot);
                            r_state <= S_ANEXT;
                        end
                        OP_SQE, OP_SQH: begin
                            // A square is never negative, so only the top clips.
                            if (term > SAT_HI) begin
                                r_sq  <= 32'sh7fffffff;
                                r_sat <= 1'b1;
                            end else begin
                                r_sq <= term[31:0];
                            end
                            r_op    <= (r_op == OP_SQE) ? OP_PSI0 : OP_PSI;
                            r_state <= S_MUL;
                        end
                        OP_PSI0: begin
                            r_acc   <= r_acc + term;
                            r_state <= S_GNEXT;
                        end
                        OP_PSI: begin
                            r_acc <= r_acc + term;
                            if (gam_on) begin
                                r_op    <= OP_GAM;
                                r_state <= S_MUL;
                            end else begin
                                r_k     <= r_k + KW'(1);
                                r_slot  <= slot_dec(r_slot);
                                r_state <= S_GNEXT;
                            end
                        end
                        OP_GAM: begin
                            r_acc   <= r_acc - term;
                            r_k     <= r_k + KW'(1);
                            r_slot  <= slot_dec(r_slot);
                            r_state <= S_GNEXT;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_ECLIP: begin
                    if (r_acc > SAT_HI) begin
                        r_e   <= 32'sh7fffffff;
                        r_sat <= 1'b1;
                    end else if (r_acc < SAT_LO) begin
                        r_e   <= 32'sh80000000;
                        r_sat <= 1'b1;
                    end else begin
                        r_e <= r_acc[31:0];
                    end
                    r_acc  <= '0;
                    r_k    <= '0;
                    r_slot <= r_head;
                    if (nps != '0) begin
                        r_op    <= OP_SQE;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_GNEXT;
                    end
                end
                S_GNEXT: begin
                    r_state <= more ? S_GFETCH : S_LCLIP;
                end
                S_GFETCH: begin
                    r_state <= S_GDISP;
                end
                S_GDISP: begin
                    if (psi_on) begin
                        r_op    <= OP_SQH;
                        r_state <= S_MUL;
                    end else if (gam_on) begin
                        r_op    <= OP_GAM;
                        r_state <= S_MUL;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_slot  <= slot_dec(r_slot);
                        r_state <= S_GNEXT;
                    end
                end
                S_LCLIP: begin
                    if (r_acc > SAT_HI) begin
                        r_lnv <= 32'sh7fffffff;
                        r_sat <= 1'b1;
                    end else if (r_acc < SAT_LO) begin
                        r_lnv <= 32'sh80000000;
                        r_sat <= 1'b1;
                    end else begin
                        r_lnv <= r_acc[31:0];
                    end
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (!r_out_valid) begin
                        r_out.individual_out <= r_item.individual;
                        r_out.residual       <= r_e;
                        r_out.log_variance   <= r_lnv;
                        r_out.saturated      <= r_sat;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= KW'(MAX_ORDER))
        else $error("usable history count exceeds the order limit");

    a_tap_in_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fetch |-> (r_k < r_seen))
        else $error("history fetched beyond the periods seen");

    a_wb_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("write-back did not present its result");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && o_q_ready && !i_q_data.is_load) |=> (r_state == S_META))
        else $error("sample word taken without starting its pass");

endmodule
`default_nettype wire

@@ src/arma_garch_panel_filter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arma_garch_panel_filter_unit
// ARMA then GARCH filter over an interleaved panel in signed fixed point.
//
//   channel  signals                            direction  moves
//   input    i_valid / o_ready / i_data         in         load or sample word
//   result   o_valid / i_ready / o_data         out        one word per sample
//   config   i_cfg_we / i_cfg_index / i_cfg_data in        order registers
//
// The back end takes a queued word only while idle. A load word is written to
// the coefficient table while the back end stays idle; a sample word runs the
// ARMA and then the GARCH tap sums, and its pass grows with the usable history
// and the number of multiplies, since the single shared multiplier and one
// history read per lag set it. A result that is not taken holds the back end in write-back.
// The front queue holds two words, so input is still taken until it fills.
// Reset is synchronous; history stores need no clearing pass.
// ----------------------------------------------------------------------------
module arma_garch_panel_filter_unit #(
    parameter int MAX_INDIVIDUALS = 256,
    parameter int MAX_ORDER       = 8,
    parameter int FRAC_BITS       = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire agpf_pkg::t_in_word i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output agpf_pkg::t_out_word     o_data,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [3:0]         i_cfg_data
);
    import agpf_pkg::*;

    logic    q_valid;
    logic    q_ready;
    t_q_word q_data;

    agpf_front #(
        .MAX_IND   (MAX_INDIVIDUALS),
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_data  (q_data)
    );

    agpf_back #(
        .MAX_IND   (MAX_INDIVIDUALS),
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_data    (q_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARMA-GARCH panel filter: a directed table of loads
// and samples, a run at maximum orders, then random panels across several order
// settings, each result checked field by field against a fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;
    import agpf_pkg::*;

    localparam int NIND      = 256;
    localparam int ORD       = 8;
    localparam int FRAC      = 16;
    localparam int CYC_LIMIT = 2000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_word   in_word = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    t_out_word  res_word;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;

    arma_garch_panel_filter_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_word),
        .o_valid(res_valid), .i_ready(res_ready), .o_data(res_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Predictor state.
    logic signed [63:0] coef_tab [4*ORD];
    logic signed [63:0] u_hist   [NIND][ORD];
    logic signed [63:0] e_hist   [NIND][ORD];
    logic signed [63:0] v_hist   [NIND][ORD];
    int                 seen_cnt [NIND];
    bit                 started  [NIND];
    logic [3:0]         order_reg [4];

    t_out_word expected_q [$];
    int        mismatches = 0;
    int        n_results  = 0;
    int        n_items    = 0;
    int        cycles     = 0;

    function automatic logic signed [63:0] floor_q(input logic signed [63:0] v);
        return v >>> FRAC;
    endfunction

    function automatic logic signed [63:0] clip(input logic signed [63:0] v, inout bit sat);
        if (v > SAT_HI) begin
            sat = 1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            sat = 1;
            return SAT_LO;
        end
        return v;
    endfunction

    function automatic int order_now(input int r);
        return (order_reg[r] > ORD) ? ORD : int'(order_reg[r]);
    endfunction

    // Apply one word to the predictor; returns 1 when a result is expected.
    function automatic bit filter_word(input t_in_word w, output t_out_word r);
        int                 ind, seen;
        logic signed [63:0] u, acc, e, lnv, ev, sq;
        bit                 sat;
        sat = 0;
        r = '0;
        if (w.opcode == OP_LOAD) begin
            coef_tab[w.coef_bank*ORD + w.coef_index] = 64'(w.coef_value);
            return 0;
        end
        ind = w.individual;
        seen = w.first_period ? 0 : seen_cnt[ind];
        u = 64'(w.sample_value);
        acc = 0;
        for (int j = 0; j < order_now(CFG_MA); j++)
            if (j == 0) acc += floor_q(coef_tab[BANK_RHO*ORD] * u);
            else if (j <= seen) acc += floor_q(coef_tab[BANK_RHO*ORD+j] * u_hist[ind][j-1]);
        for (int j = 0; j < order_now(CFG_AR); j++)
            if (j + 1 <= seen) acc -= floor_q(coef_tab[BANK_LAMBDA*ORD+j] * e_hist[ind][j]);
        e = clip(acc, sat);
        acc = 0;
        for (int j = 0; j < order_now(CFG_ARCH); j++) begin
            if (j == 0 || j <= seen) begin
                ev = (j == 0) ? e : e_hist[ind][j-1];
                sq = clip(floor_q(ev * ev), sat);
                acc += floor_q(coef_tab[BANK_PSI*ORD+j] * sq);
            end
        end
        for (int j = 0; j < order_now(CFG_GARCH); j++)
            if (j + 1 <= seen) acc -= floor_q(coef_tab[BANK_GAMMA*ORD+j] * v_hist[ind][j]);
        lnv = clip(acc, sat);
        for (int k = ORD - 1; k > 0; k--) begin
            u_hist[ind][k] = u_hist[ind][k-1];
            e_hist[ind][k] = e_hist[ind][k-1];
            v_hist[ind][k] = v_hist[ind][k-1];
        end
        u_hist[ind][0] = u;
        e_hist[ind][0] = e;
        v_hist[ind][0] = lnv;
        seen_cnt[ind] = (seen < ORD) ? seen + 1 : ORD;
        started[ind] = 1;
        r.individual_out = w.individual;
        r.residual = e[31:0];
        r.log_variance = lnv[31:0];
        r.saturated = sat;
        return 1;
    endfunction

    // Result side: random stalls, compare against oldest expectation.
    initial begin
        t_out_word exp_w;
        int        stall;
        @(posedge clk iff rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk iff res_valid);
            n_results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", res_word);
            end else begin
                exp_w = expected_q.pop_front();
                if (res_word.individual_out !== exp_w.individual_out ||
                    res_word.residual !== exp_w.residual ||
                    res_word.log_variance !== exp_w.log_variance ||
                    res_word.saturated !== exp_w.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ind %0d e %h v %h s %b, got ind %0d e %h v %h s %b",
                                 exp_w.individual_out, exp_w.residual, exp_w.log_variance,
                                 exp_w.saturated, res_word.individual_out, res_word.residual,
                                 res_word.log_variance, res_word.saturated);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    // Send one word after a random gap; queue the expectation on acceptance.
    // Valid stays up after acceptance so that a word with no gap follows at once.
    task automatic send_word(input t_in_word w, input bit gaps);
        t_out_word r;
        int        gap;
        gap = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk iff in_ready);
        if (filter_word(w, r)) expected_q.push_back(r);
        n_items++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        // A trailing load can still be in flight.
        repeat (200) @(posedge clk);
    endtask

    task automatic write_order(input logic [1:0] idx, input logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        order_reg[idx] = val;
        @(posedge clk);
    endtask

    function automatic t_in_word load_w(input logic [1:0] bank, input logic [2:0] idx,
                                        input logic [31:0] val);
        t_in_word w;
        w = t_in_word'({$urandom, $urandom, $urandom});
        w.opcode = OP_LOAD;
        w.coef_bank = bank;
        w.coef_index = idx;
        w.coef_value = val;
        return w;
    endfunction

    function automatic t_in_word sample_w(input logic [7:0] ind, input bit first,
                                          input logic [31:0] val);
        t_in_word w;
        w = t_in_word'({$urandom, $urandom, $urandom});
        w.opcode = OP_SAMPLE;
        w.individual = ind;
        w.first_period = first;
        w.sample_value = val;
        return w;
    endfunction

    // Random coefficient in a moderate range, with the odd extreme.
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2*524288)) - 524288);
        endcase
    endfunction

    typedef struct {
        t_in_word  w;
        bit        check;
        t_out_word r;
    } t_row;

    t_row dir_tab [$];

    initial begin
        t_out_word pr;
        t_row      row;
        int        nind, ind, k;
        logic [7:0] panel [8];
        for (int i = 0; i < 4*ORD; i++) coef_tab[i] = 0;
        for (int i = 0; i < NIND; i++) begin
            seen_cnt[i] = 0;
            started[i] = 0;
        end
        order_reg[CFG_AR] = 0;
        order_reg[CFG_MA] = 1;
        order_reg[CFG_GARCH] = 0;
        order_reg[CFG_ARCH] = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed results where obvious, else predictor.
        // After reset every coefficient is zero, so the result is all zero.
        dir_tab.push_back('{sample_w(8'd0, 1, 32'h7fff_ffff), 1, '{8'd0, 0, 0, 1'b0}});
        dir_tab.push_back('{load_w(BANK_RHO, 3'd0, 32'h0001_0000), 0, '0});
        dir_tab.push_back('{load_w(BANK_PSI, 3'd0, 32'h0001_0000), 0, '0});
        dir_tab.push_back('{sample_w(8'd255, 1, 32'h0002_0000), 1,
                            '{8'd255, 32'h0002_0000, 32'h0004_0000, 1'b0}});
        // Square of the most negative residual clips.
        dir_tab.push_back('{sample_w(8'd255, 0, 32'h8000_0000), 1,
                            '{8'd255, 32'h8000_0000, 32'h7fff_ffff, 1'b1}});
        dir_tab.push_back('{load_w(BANK_RHO, 3'd0, 32'h8000_0000), 0, '0});
        dir_tab.push_back('{sample_w(8'd7, 1, 32'h8000_0000), 1, '0});
        dir_tab.push_back('{sample_w(8'd7, 0, 32'h7fff_ffff), 1, '0});
        dir_tab.push_back('{load_w(BANK_LAMBDA, 3'd7, 32'h7fff_ffff), 0, '0});
        dir_tab.push_back('{load_w(BANK_GAMMA, 3'd7, 32'h8000_0000), 0, '0});
        dir_tab.push_back('{load_w(BANK_PSI, 3'd7, 32'hffff_0000), 0, '0});
        dir_tab.push_back('{load_w(BANK_RHO, 3'd7, 32'h0000_8000), 0, '0});
        dir_tab.push_back('{load_w(BANK_RHO, 3'd0, 32'h0001_0000), 0, '0});
        for (int i = 0; i < dir_tab.size(); i++) begin
            row = dir_tab[i];
            if (row.check && filter_word(row.w, pr)) begin
                // Undo the predictor step by replaying through send_word below.
            end
        end
        // Reset predictor to replay the table through the normal path.
        for (int i = 0; i < 4*ORD; i++) coef_tab[i] = 0;
        for (int i = 0; i < NIND; i++) seen_cnt[i] = 0;
        for (int i = 0; i < dir_tab.size(); i++) begin
            row = dir_tab[i];
            send_word(row.w, 0);
            if (row.check && expected_q.size() != 0 && row.r != '0) begin
                // Typed result overrides the predicted one for the easy rows.
                expected_q[expected_q.size()-1] = row.r;
            end
        end
        drain_results();

        // Max orders, then an over-range value that acts as the maximum.
        write_order(CFG_AR, 4'd8);
        write_order(CFG_MA, 4'd8);
        write_order(CFG_GARCH, 4'd8);
        write_order(CFG_ARCH, 4'd15);
        for (int s = 0; s < 12; s++) send_word(sample_w(8'd7, 0, rand_sample()), 1);
        drain_results();

        // Random phases: the first keeps the current orders, the second sets all to zero, the rest draw their own.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 1) begin
                for (int r = 0; r < 4; r++) write_order(r[1:0], 4'd0);
            end else if (ph > 1) begin
                for (int r = 0; r < 4; r++) write_order(r[1:0], 4'($urandom_range(0, 15)));
            end
            nind = $urandom_range(1, 8);
            for (int i = 0; i < nind; i++) panel[i] = 8'($urandom_range(0, 255));
            for (int i = 0; i < 8; i++)
                send_word(load_w(2'($urandom), 3'($urandom), rand_coef()), 1);
            for (int n = 0; n < 180; n++) begin
                k = $urandom_range(0, nind - 1);
                ind = panel[k];
                if ($urandom_range(0, 9) == 0)
                    send_word(load_w(2'($urandom), 3'($urandom), rand_coef()), 1);
                else
                    send_word(sample_w(8'(ind), !started[ind] || $urandom_range(0, 30) == 0,
                                       rand_sample()), 1);
                if (n == 90 && ph == 3)
                    drain_results();
            end
            drain_results();
        end

        drain_results();
        $display("Covered %0d input words and %0d result words under the reset, maximum,",
                 n_items, n_results);
        $display("zero and random order settings.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
